>>> src/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timer expiry queue
// Opcodes, result kinds, table size and the front-to-back command record.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = 4;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = 5;
    localparam int TIME_W     = 64;
    localparam logic [TIME_W-1:0] ALL_ONES = '1;

    typedef enum logic [1:0] {
        OP_ARM_ONE = 2'd0,
        OP_ARM_PER = 2'd1,
        OP_CANCEL  = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ARM    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_FIRED  = 2'd2,
        KIND_DONE   = 2'd3
    } t_kind;

    // Command handed from the front to the back through the queue.
    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic              slot_ok;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] sum;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_GRID,
        ST_SUB,
        ST_DIV,
        ST_BASE,
        ST_FIRE,
        ST_MIN,
        ST_EMIT
    } t_state;

endpackage

>>> src/teq_front.sv
// ----------------------------------------------------------------------------
// teq_front: input stage and command queue
// Registers each item, checks the slot, precomputes the saturating arm
// expiry and keeps a two-entry queue in front of the engine.
// ----------------------------------------------------------------------------
module teq_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_op,
    input  logic [3:0]            i_slot,
    input  logic [63:0]           i_delay,
    input  logic [63:0]           i_now,
    output logic                  o_cmd_valid,
    output teq_pkg::t_cmd         o_cmd,
    input  logic                  i_cmd_take
);
    import teq_pkg::*;

    t_cmd        r_q [2];
    logic        r_rd, n_rd;
    logic        r_wr, n_wr;
    logic [1:0]  r_cnt, n_cnt;
    t_cmd        w_cmd;
    logic [TIME_W:0] w_sum;
    logic        w_push, w_pop;

    assign w_sum = {1'b0, i_now} + {1'b0, i_delay};

    always_comb begin
        w_cmd.op      = t_op'(i_op);
        w_cmd.slot    = i_slot;
        w_cmd.slot_ok = ({{(32-SLOT_W){1'b0}}, i_slot} < 32'(NUM_TIMERS));
        w_cmd.delay   = i_delay;
        w_cmd.now     = i_now;
        w_cmd.sum     = w_sum[TIME_W] ? ALL_ONES : w_sum[TIME_W-1:0];
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_pop       = o_cmd_valid && i_cmd_take;

    always_comb begin
        n_rd  = r_rd ^ w_pop;
        n_wr  = r_wr ^ w_push;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

>>> src/teq_div.sv
// ----------------------------------------------------------------------------
// teq_div: 64-bit restoring remainder unit
// Computes num % den one quotient bit per cycle.
// ----------------------------------------------------------------------------
module teq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_rem
);
    import teq_pkg::*;

    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [64:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;
    logic [64:0] w_sub;

    assign w_sh   = {r_rem[63:0], r_num[63]};
    assign w_sub  = w_sh - {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == 7'd0);
    assign o_rem  = r_rem[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= w_sub[64] ? w_sh : w_sub;
        end
    end

endmodule

>>> src/teq_back.sv
// ----------------------------------------------------------------------------
// teq_back: timer table and command engine
// Holds the slot table, carries out arm, cancel and tick commands and
// emits result items through a one-entry output register.
// ----------------------------------------------------------------------------
module teq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  teq_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_kind,
    output logic [3:0]    o_fired_slot,
    output logic          o_ok,
    output logic [63:0]   o_next_expiry,
    output logic [4:0]    o_active_count,
    output logic          o_last
);
    import teq_pkg::*;

    logic [TIME_W-1:0] r_exp [NUM_TIMERS];
    logic [TIME_W-1:0] r_per [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_armed, n_armed;
    logic [NUM_TIMERS-1:0] r_due, n_due;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [TIME_W-1:0] r_earliest, n_earliest;
    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_pick, n_pick;
    logic [TIME_W-1:0] r_best, n_best;
    logic [TIME_W-1:0] r_t, n_t;
    logic [TIME_W-1:0] r_newexp, n_newexp;
    logic              r_mode, n_mode;   // 1: finishing arm/cancel, 0: tick

    // Slots in firing order, recorded as they are picked.
    logic [IDX_W-1:0]  r_log [NUM_TIMERS];
    logic [IDX_W:0]    r_nlog, n_nlog;
    logic [IDX_W:0]    r_elog, n_elog;

    logic              r_ov, n_ov;
    t_kind             r_okind, n_okind;
    logic [SLOT_W-1:0] r_oslot, n_oslot;
    logic              r_ook, n_ook;
    logic              r_olast, n_olast;

    logic              w_wr_exp;
    logic [IDX_W-1:0]  w_wr_idx;
    logic              w_wr_per;
    logic [TIME_W-1:0] w_per_val;
    logic              w_div_start;
    logic              w_div_done;
    logic [TIME_W-1:0] w_rem;
    logic [TIME_W-1:0] w_num;
    logic [TIME_W:0]   w_add;
    logic [TIME_W-1:0] w_exp_i;
    logic [TIME_W-1:0] w_per_p;
    logic              w_out_free;

    teq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_per_p),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    assign w_num      = r_cmd.now - r_t;
    assign w_exp_i    = r_exp[r_idx];
    assign w_per_p    = r_per[r_pick];
    assign w_out_free = !r_ov || !i_stall;

    assign o_valid        = r_ov;
    assign o_kind         = r_okind;
    assign o_fired_slot   = r_oslot;
    assign o_ok           = r_ook;
    assign o_next_expiry  = r_earliest;
    assign o_active_count = r_total;
    assign o_last         = r_olast;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_found     = r_found;
        n_pick      = r_pick;
        n_best      = r_best;
        n_t         = r_t;
        n_newexp    = r_newexp;
        n_mode      = r_mode;
        n_nlog      = r_nlog;
        n_elog      = r_elog;
        n_armed     = r_armed;
        n_due       = r_due;
        n_total     = r_total;
        n_earliest  = r_earliest;
        n_ov        = r_ov && i_stall;
        n_okind     = r_okind;
        n_oslot     = r_oslot;
        n_ook       = r_ook;
        n_olast     = r_olast;
        o_cmd_take  = 1'b0;
        w_wr_exp    = 1'b0;
        w_wr_idx    = r_pick;
        w_wr_per    = 1'b0;
        w_per_val   = '0;
        w_div_start = 1'b0;
        w_add       = '0;

        unique case (r_state)
            ST_IDLE: begin
                n_nlog = '0;
                n_elog = '0;
                if (i_cmd_valid && !r_ov) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    n_idx      = '0;
                    n_best     = ALL_ONES;
                    n_found    = 1'b0;
                    n_due      = '0;
                    n_state    = ST_MIN;
                    n_okind    = KIND_ARM;
                    n_oslot    = i_cmd.slot;
                    n_ook      = i_cmd.slot_ok;
                    n_olast    = 1'b1;
                    n_mode     = 1'b1;
                    unique case (i_cmd.op)
                        OP_ARM_ONE, OP_ARM_PER: begin
                            if (i_cmd.slot_ok) begin
                                w_wr_exp  = 1'b1;
                                w_wr_per  = 1'b1;
                                w_wr_idx  = i_cmd.slot[IDX_W-1:0];
                                n_newexp  = i_cmd.sum;
                                w_per_val = (i_cmd.op == OP_ARM_PER) ? i_cmd.delay : '0;
                                if (!r_armed[i_cmd.slot[IDX_W-1:0]]) begin
                                    n_armed[i_cmd.slot[IDX_W-1:0]] = 1'b1;
                                    n_total = r_total + CNT_W'(1);
                                end
                            end
                        end
                        OP_CANCEL: begin
                            n_okind = KIND_CANCEL;
                            n_ook   = i_cmd.slot_ok && r_armed[i_cmd.slot[IDX_W-1:0]];
                            if (n_ook) begin
                                n_armed[i_cmd.slot[IDX_W-1:0]] = 1'b0;
                                n_total = r_total - CNT_W'(1);
                            end
                        end
                        OP_TICK: begin
                            n_mode  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            // Mark every armed slot due at this tick, one slot per cycle.
            ST_SCAN: begin
                n_due[r_idx] = r_armed[r_idx] && (w_exp_i <= r_cmd.now);
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(NUM_TIMERS - 1)) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = ST_PICK;
                end
            end
            // Find the due slot with the smallest expiry, lowest slot on ties.
            ST_PICK: begin
                if (r_due[r_idx] && (!r_found || w_exp_i < r_best)) begin
                    n_found = 1'b1;
                    n_pick  = r_idx;
                    n_best  = w_exp_i;
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(NUM_TIMERS - 1)) begin
                    n_idx = '0;
                    if (n_found) begin
                        n_state = ST_GRID;
                    end else begin
                        n_best  = ALL_ONES;
                        n_state = ST_MIN;
                    end
                end
            end
            ST_GRID: begin
                n_due[r_pick] = 1'b0;
                n_nlog        = r_nlog + (IDX_W+1)'(1);
                if (w_per_p == '0) begin
                    n_armed[r_pick] = 1'b0;
                    n_total = r_total - CNT_W'(1);
                    n_state = ST_FIRE;
                end else begin
                    w_add = {1'b0, r_best} + {1'b0, w_per_p};
                    if (w_add[TIME_W]) begin
                        n_newexp = ALL_ONES;
                        n_state  = ST_FIRE;
                    end else if (w_add[TIME_W-1:0] > r_cmd.now) begin
                        n_newexp = w_add[TIME_W-1:0];
                        n_state  = ST_FIRE;
                    end else begin
                        n_t     = w_add[TIME_W-1:0];
                        n_state = ST_SUB;
                    end
                end
            end
            // The overrun distance now - t goes to the divider.
            ST_SUB: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_t     = r_cmd.now - w_rem;
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                w_add    = {1'b0, r_t} + {1'b0, w_per_p};
                n_newexp = w_add[TIME_W] ? ALL_ONES : w_add[TIME_W-1:0];
                n_state  = ST_FIRE;
            end
            ST_FIRE: begin
                if (r_armed[r_pick]) begin
                    w_wr_exp = 1'b1;
                end
                n_idx   = '0;
                n_found = 1'b0;
                n_state = ST_PICK;
            end
            // Recompute the earliest pending expiry over armed slots.
            ST_MIN: begin
                if (r_armed[r_idx] && w_exp_i < r_best) begin
                    n_best = w_exp_i;
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(NUM_TIMERS - 1)) begin
                    n_earliest = (r_armed[r_idx] && w_exp_i < r_best) ? w_exp_i : r_best;
                    n_idx      = '0;
                    if (r_mode) begin
                        n_ov    = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            // Emit fired results in firing order, then the closing result.
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ov  = 1'b1;
                    n_ook = 1'b1;
                    if (r_elog != r_nlog) begin
                        n_okind = KIND_FIRED;
                        n_oslot = SLOT_W'(r_log[r_elog[IDX_W-1:0]]);
                        n_olast = 1'b0;
                        n_elog  = r_elog + (IDX_W+1)'(1);
                    end else begin
                        n_okind = KIND_DONE;
                        n_oslot = '0;
                        n_olast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_armed    <= '0;
            r_total    <= '0;
            r_earliest <= ALL_ONES;
            r_ov       <= 1'b0;
            r_found    <= 1'b0;
            r_nlog     <= '0;
            r_elog     <= '0;
        end else begin
            r_state    <= n_state;
            r_armed    <= n_armed;
            r_total    <= n_total;
            r_earliest <= n_earliest;
            r_ov       <= n_ov;
            r_found    <= n_found;
            r_nlog     <= n_nlog;
            r_elog     <= n_elog;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_pick   <= n_pick;
        r_best   <= n_best;
        r_t      <= n_t;
        r_newexp <= n_newexp;
        r_mode   <= n_mode;
        r_due    <= n_due;
        r_okind  <= n_okind;
        r_oslot  <= n_oslot;
        r_ook    <= n_ook;
        r_olast  <= n_olast;
        if (r_state == ST_GRID) begin
            r_log[r_nlog[IDX_W-1:0]] <= r_pick;
        end
        if (w_wr_exp) begin
            r_exp[w_wr_idx] <= (r_state == ST_IDLE) ? n_newexp : r_newexp;
        end
        if (w_wr_per) begin
            r_per[w_wr_idx] <= w_per_val;
        end
    end

endmodule

>>> src/timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue: table of timer slots fired in expiry order
// A front stage queues arm, cancel and tick items; a back engine keeps the
// slot table, fires due slots and answers with result items.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  input     in         i_valid, o_stall, i_op, i_slot, i_delay, i_now
//  result    out        o_valid, i_stall, o_kind, o_fired_slot, o_ok,
//                       o_next_expiry, o_active_count, o_last
//
// An arm or cancel item ends with the sweep over the sixteen slots that
// recomputes the earliest expiry. A tick scans the slots, then sweeps them
// anew to pick each due slot in turn, and runs a divide for each periodic
// slot that overran, since its catch-up remainder comes from a one bit
// per cycle divider. Synchronous reset clears the armed bits, the count,
// the earliest expiry and all handshake state; slot expiry and period
// words are written before they are read. A stalled result holds, and
// the front queue keeps taking items until its two entries are full.
// ----------------------------------------------------------------------------
module timer_expiry_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_slot,
    input  logic [63:0] i_delay,
    input  logic [63:0] i_now,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_fired_slot,
    output logic        o_ok,
    output logic [63:0] o_next_expiry,
    output logic [4:0]  o_active_count,
    output logic        o_last
);
    import teq_pkg::*;

    // Queue between the item front and the table engine.
    logic w_cmd_valid;
    logic w_cmd_take;
    t_cmd w_cmd;

    teq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_slot      (i_slot),
        .i_delay     (i_delay),
        .i_now       (i_now),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    teq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_take     (w_cmd_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_fired_slot   (o_fired_slot),
        .o_ok           (o_ok),
        .o_next_expiry  (o_next_expiry),
        .o_active_count (o_active_count),
        .o_last         (o_last)
    );

endmodule
